### rtl/core/gasp_pkg.sv
// Shared types, sizes and status codes of the glyph atlas shelf packer.
package gasp_pkg;

	localparam int unsigned ATLAS_SIZE = 1024;
	localparam int unsigned MAX_PAGES  = 16;

	localparam int unsigned DIM_W   = 10;
	localparam int unsigned X_W     = 11;
	localparam int unsigned PAGE_W  = 4;
	localparam int unsigned SLOT_W  = 20;
	localparam int unsigned LIMIT_W = 5;
	localparam int unsigned CMP_W   = 12;

	localparam logic [SLOT_W-1:0] SLOT_MAX = {SLOT_W{1'b1}};

	typedef enum logic [1:0] {
		ST_PLACED   = 2'd0,
		ST_MISSING  = 2'd1,
		ST_TOO_TALL = 2'd2,
		ST_NO_PAGE  = 2'd3
	} status_t;

	typedef struct packed {
		logic              glyph_found;
		logic [DIM_W-1:0]  glyph_width;
		logic [DIM_W-1:0]  glyph_height;
		logic              first_of_batch;
		logic              last_of_batch;
	} in_item_t;

	typedef struct packed {
		status_t           status;
		logic [PAGE_W-1:0] page_index;
		logic [SLOT_W-1:0] slot_index;
		logic [X_W-1:0]    x_pos;
		logic [DIM_W-1:0]  y_pos;
		logic              page_opened;
	} out_item_t;

endpackage

### rtl/core/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer: input register, placement logic, result register.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid / in_stall     | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall   | out_data (out_item_t)
//  cfg     | input     | cfg_we                  | cfg_wdata (page limit)
//
// One glyph per cycle while the output is not stalled; a glyph passes the input register, then the result register.
// The placement adds and compares on the cursor registers sit in one stage.
// Reset restores page 0, cursor at (1,1), page limit 16.
// A stalled result holds in the output register while the input register
// still takes one more glyph.
module glyph_atlas_shelf_packer
	import gasp_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [LIMIT_W-1:0]  cfg_wdata
);

	logic                valid_s1;
	in_item_t            item_s1;
	logic                valid_s2;
	out_item_t           item_s2;
	logic                move_s1;

	logic [LIMIT_W-1:0]  page_limit_q;
	logic [PAGE_W-1:0]   current_page_q;
	logic [DIM_W-1:0]    committed_row_q;
	logic [X_W-1:0]      cursor_x_q;
	logic [DIM_W-1:0]    shelf_y_q;
	logic [DIM_W-1:0]    shelf_bottom_q;
	logic [SLOT_W-1:0]   glyph_count_q;

	logic [X_W-1:0]      cx0, cx1, cx2;
	logic [DIM_W-1:0]    sy0, sy1, sy2, sb0, sb1, sb_new;
	logic [CMP_W-1:0]    x_sum, y_sum, row_sum;
	logic [DIM_W-1:0]    shelf_end, row1, row_new;
	logic [LIMIT_W-1:0]  lim;
	logic                wrap, full, tall, no_page, opened, placed;
	logic [PAGE_W-1:0]   page1;
	logic [SLOT_W-1:0]   count1, count_new;
	logic [X_W-1:0]      cx_new;
	logic [DIM_W-1:0]    sy_new;
	out_item_t           result;

	assign move_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !move_s1;
	assign out_valid = valid_s2;
	assign out_data  = item_s2;

	always_comb begin
		cx0 = item_s1.first_of_batch ? X_W'(1) : cursor_x_q;
		sy0 = item_s1.first_of_batch ? DIM_W'(1) : shelf_y_q;
		sb0 = item_s1.first_of_batch ? DIM_W'(1) : shelf_bottom_q;

		tall  = item_s1.glyph_height >= DIM_W'(ATLAS_SIZE - 2);
		x_sum = CMP_W'(cx0) + CMP_W'(item_s1.glyph_width) + CMP_W'(1);
		wrap  = x_sum >= CMP_W'(ATLAS_SIZE);
		cx1   = wrap ? X_W'(1) : cx0;
		sy1   = wrap ? sb0 : sy0;

		y_sum = CMP_W'(committed_row_q) + CMP_W'(sy1) + CMP_W'(item_s1.glyph_height)
			+ CMP_W'(1);
		full  = y_sum >= CMP_W'(ATLAS_SIZE);

		if (page_limit_q == '0) begin
			lim = LIMIT_W'(1);
		end else if (page_limit_q > LIMIT_W'(MAX_PAGES)) begin
			lim = LIMIT_W'(MAX_PAGES);
		end else begin
			lim = page_limit_q;
		end
		no_page = (LIMIT_W'(current_page_q) + LIMIT_W'(1)) >= lim;

		opened = item_s1.glyph_found && !tall && full && !no_page;
		placed = item_s1.glyph_found && !tall && !(full && no_page);

		cx2    = opened ? X_W'(1) : cx1;
		sy2    = opened ? DIM_W'(1) : sy1;
		sb1    = opened ? DIM_W'(1) : sb0;
		row1   = opened ? '0 : committed_row_q;
		page1  = current_page_q + PAGE_W'(opened);
		count1 = opened ? '0 : glyph_count_q;

		shelf_end = sy2 + item_s1.glyph_height + DIM_W'(1);

		if (placed) begin
			cx_new    = cx2 + X_W'(item_s1.glyph_width) + X_W'(1);
			sy_new    = sy2;
			sb_new    = (shelf_end > sb1) ? shelf_end : sb1;
			count_new = (count1 < SLOT_MAX) ? count1 + SLOT_W'(1) : count1;
		end else begin
			cx_new    = cx0;
			sy_new    = sy0;
			sb_new    = sb0;
			count_new = glyph_count_q;
		end

		row_sum = CMP_W'(row1) + CMP_W'(sb_new);
		row_new = (row_sum > CMP_W'(ATLAS_SIZE - 1)) ? DIM_W'(ATLAS_SIZE - 1)
			: row_sum[DIM_W-1:0];

		result = '0;
		result.page_index = page1;
		if (!item_s1.glyph_found) begin
			result.status = ST_MISSING;
		end else if (tall) begin
			result.status = ST_TOO_TALL;
		end else if (!placed) begin
			result.status = ST_NO_PAGE;
		end else begin
			result.status      = ST_PLACED;
			result.slot_index  = count1;
			result.x_pos       = cx2;
			result.y_pos       = row1 + sy2;
			result.page_opened = opened;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			page_limit_q    <= LIMIT_W'(MAX_PAGES);
			current_page_q  <= '0;
			committed_row_q <= '0;
			cursor_x_q      <= X_W'(1);
			shelf_y_q       <= DIM_W'(1);
			shelf_bottom_q  <= DIM_W'(1);
			glyph_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				page_limit_q <= cfg_wdata;
			end
			if (!valid_s1 || move_s1) begin
				valid_s1 <= in_valid;
			end
			if (move_s1) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (move_s1) begin
				current_page_q <= page1;
				glyph_count_q  <= count_new;
				if (item_s1.last_of_batch) begin
					committed_row_q <= row_new;
					cursor_x_q      <= X_W'(1);
					shelf_y_q       <= DIM_W'(1);
					shelf_bottom_q  <= DIM_W'(1);
				end else begin
					committed_row_q <= row1;
					cursor_x_q      <= cx_new;
					shelf_y_q       <= sy_new;
					shelf_bottom_q  <= sb_new;
				end
			end
		end
	end

	// payload registers: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (!valid_s1 || move_s1) begin
			item_s1 <= in_data;
		end
		if (move_s1) begin
			item_s2 <= result;
		end
	end

endmodule

### rtl/core/gasp_checker.sv
// Port-level assertions for the glyph atlas shelf packer and their bind.
module gasp_checker
	import gasp_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input in_item_t            in_data,
	input logic                out_valid,
	input logic                out_stall,
	input out_item_t           out_data,
	input logic                cfg_we,
	input logic [LIMIT_W-1:0]  cfg_wdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_unplaced_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_PLACED |->
		out_data.slot_index == '0 && out_data.x_pos == '0 &&
		out_data.y_pos == '0 && !out_data.page_opened)
		else $error("unplaced glyph carries a position");

	a_new_page_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.page_opened |->
		out_data.status == ST_PLACED && out_data.slot_index == '0 &&
		out_data.x_pos == X_W'(1) && out_data.y_pos == DIM_W'(1) &&
		out_data.page_index != '0)
		else $error("glyph that opened a page is not at the page origin");

	a_placed_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_PLACED |->
		out_data.x_pos != '0 && out_data.y_pos != '0)
		else $error("placed glyph touches the page border");

endmodule

bind glyph_atlas_shelf_packer gasp_checker u_gasp_checker (.*);

### sim/glyph_atlas_shelf_packer_tb.sv
// Self-checking testbench for the glyph atlas shelf packer: random bursts, stalls and page limits.
module glyph_atlas_shelf_packer_tb;
	import gasp_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD = 400;

	typedef enum logic [1:0] {
		RX_FREE   = 2'd0,
		RX_LIGHT  = 2'd1,
		RX_HEAVY  = 2'd2,
		RX_TOGGLE = 2'd3
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [LIMIT_W-1:0] cfg_wdata = '0;

	glyph_atlas_shelf_packer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// packer state as predicted
	logic [LIMIT_W-1:0] page_cap = LIMIT_W'(16);
	logic [PAGE_W-1:0]  atlas_page = '0;
	logic [DIM_W-1:0]   atlas_row = '0;
	logic [X_W-1:0]     pen_x = X_W'(1);
	logic [DIM_W-1:0]   shelf_top = DIM_W'(1);
	logic [DIM_W-1:0]   shelf_floor = DIM_W'(1);
	logic [SLOT_W-1:0]  page_slots = '0;

	in_item_t    glyph_queue[$];
	out_item_t   placements_due[$];
	out_item_t   want;
	logic        glyph_taken = 1'b0;
	int unsigned glyphs_queued = 0;
	int unsigned glyphs_in = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned limit_writes = 0;
	int unsigned pages_opened = 0;
	int unsigned status_tally[4] = '{0, 0, 0, 0};

	int unsigned burst_left = 0;
	int unsigned idle_left = 0;
	int unsigned hold_left = 0;
	int unsigned long_holds = 0;
	int unsigned mode_left = 0;
	rx_mode_t    stall_mode = RX_FREE;

	int unsigned phase_caps[9] = '{3, 0, 5, 8, 11, 13, 17, 31, 16};
	int unsigned phase_sizes[9] = '{130, 40, 130, 130, 130, 120, 150, 150, 150};

	function automatic out_item_t place_glyph(input in_item_t g);
		out_item_t r;
		int unsigned w, h, cx, sy, sb, cap, row;
		w = 32'(g.glyph_width);
		h = 32'(g.glyph_height);
		r = '0;
		r.status = ST_PLACED;
		if (g.first_of_batch) begin
			pen_x = X_W'(1);
			shelf_top = DIM_W'(1);
			shelf_floor = DIM_W'(1);
		end
		r.page_index = atlas_page;
		if (!g.glyph_found) begin
			r.status = ST_MISSING;
		end else if (h + 2 >= ATLAS_SIZE) begin
			r.status = ST_TOO_TALL;
		end else begin
			cx = 32'(pen_x);
			sy = 32'(shelf_top);
			sb = 32'(shelf_floor);
			if (cx + w + 1 >= ATLAS_SIZE) begin
				cx = 1;
				sy = sb;
			end
			if (32'(atlas_row) + sy + h + 1 >= ATLAS_SIZE) begin
				cap = 32'(page_cap);
				if (cap < 1)
					cap = 1;
				if (cap > MAX_PAGES)
					cap = MAX_PAGES;
				if (32'(atlas_page) + 1 >= cap) begin
					r.status = ST_NO_PAGE;
				end else begin
					atlas_page = atlas_page + 1'b1;
					atlas_row = '0;
					page_slots = '0;
					cx = 1;
					sy = 1;
					sb = 1;
					r.page_opened = 1'b1;
					r.page_index = atlas_page;
				end
			end
			if (r.status == ST_PLACED) begin
				r.x_pos = X_W'(cx);
				r.y_pos = DIM_W'(32'(atlas_row) + sy);
				r.slot_index = page_slots;
				if (page_slots != SLOT_MAX)
					page_slots = page_slots + 1'b1;
				pen_x = X_W'(cx + w + 1);
				shelf_top = DIM_W'(sy);
				if (sy + h + 1 > sb)
					sb = sy + h + 1;
				shelf_floor = DIM_W'(sb);
			end
		end
		if (g.last_of_batch) begin
			row = 32'(atlas_row) + 32'(shelf_floor);
			atlas_row = DIM_W'((row > ATLAS_SIZE - 1) ? ATLAS_SIZE - 1 : row);
			pen_x = X_W'(1);
			shelf_top = DIM_W'(1);
			shelf_floor = DIM_W'(1);
		end
		return r;
	endfunction

	task automatic queue_glyph(input logic found, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic first, input logic last);
		in_item_t g;
		g.glyph_found = found;
		g.glyph_width = w;
		g.glyph_height = h;
		g.first_of_batch = first;
		g.last_of_batch = last;
		glyph_queue.insert(glyph_queue.size(), g);
		glyphs_queued++;
	endtask

	task automatic queue_random_glyphs(input int unsigned n);
		int unsigned made, len, pick;
		logic [DIM_W-1:0] w, h;
		logic found, first, last;
		made = 0;
		while (made < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				queue_glyph(1'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 1023)),
					DIM_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				made++;
			end else begin
				len = $urandom_range(1, 10);
				for (int unsigned i = 0; i < len; i++) begin
					found = ($urandom_range(0, 19) != 0);
					pick = $urandom_range(0, 99);
					if (pick < 65) begin
						w = DIM_W'($urandom_range(0, 48));
						h = DIM_W'($urandom_range(0, 32));
					end else if (pick < 92) begin
						w = DIM_W'($urandom_range(0, 250));
						h = DIM_W'($urandom_range(0, 100));
					end else if (pick < 98) begin
						w = DIM_W'($urandom_range(0, 1023));
						h = DIM_W'($urandom_range(0, 300));
					end else begin
						w = DIM_W'($urandom_range(0, 1) ? $urandom_range(1015, 1023) : 0);
						h = DIM_W'(($urandom_range(0, 4) < 3) ? $urandom_range(1022, 1023)
							: $urandom_range(1015, 1021));
					end
					first = (i == 0) ? ($urandom_range(0, 9) != 0)
						: ($urandom_range(0, 29) == 0);
					last = (i == len - 1) ? ($urandom_range(0, 9) != 0)
						: ($urandom_range(0, 29) == 0);
					queue_glyph(found, w, h, first, last);
					made++;
				end
			end
		end
	endtask

	task automatic await_drain();
		while (results_seen != glyphs_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_page_limit(input logic [LIMIT_W-1:0] v);
		await_drain();
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		limit_writes++;
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// sender: bursts of transfers separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || glyph_taken) begin
			if (idle_left != 0) begin
				idle_left--;
				in_valid <= 1'b0;
			end else if (glyph_queue.size() != 0) begin
				in_data <= glyph_queue.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					idle_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern, plus two long hold-offs
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if ((long_holds == 0 && glyphs_in >= 300)
				|| (long_holds == 1 && glyphs_in >= 750)) begin
			long_holds++;
			hold_left = LONG_HOLD;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			case (stall_mode)
				RX_FREE: out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	always @(posedge clk) begin
		glyph_taken <= in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_we)
				page_cap = cfg_wdata;
			if (in_valid && !in_stall) begin
				placements_due.insert(placements_due.size(), place_glyph(in_data));
				glyphs_in++;
			end
			if (out_valid && !out_stall) begin
				if (placements_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result with nothing pending: %p", out_data);
				end else begin
					want = placements_due.pop_front();
					results_seen++;
					status_tally[want.status]++;
					if (want.page_opened)
						pages_opened++;
					if (out_data !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result %0d: want status %0d page %0d slot %0d x %0d y %0d open %0b",
								results_seen, want.status, want.page_index,
								want.slot_index, want.x_pos, want.y_pos, want.page_opened);
							$display("result %0d: got  status %0d page %0d slot %0d x %0d y %0d open %0b",
								results_seen, out_data.status, out_data.page_index,
								out_data.slot_index, out_data.x_pos, out_data.y_pos,
								out_data.page_opened);
						end
					end
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		queue_glyph(1'b1, 10'd0, 10'd0, 1'b1, 1'b0);
		queue_glyph(1'b1, 10'd1023, 10'd0, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'h2AA, 10'h155, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'h155, 10'h2AA, 1'b0, 1'b0);
		queue_glyph(1'b0, 10'd1023, 10'd1023, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'd5, 10'd1022, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'd5, 10'd1023, 1'b0, 1'b1);
		queue_glyph(1'b1, 10'd7, 10'd1021, 1'b1, 1'b1);
		queue_glyph(1'b1, 10'd3, 10'd0, 1'b1, 1'b1);
		set_page_limit(LIMIT_W'(1));
		queue_glyph(1'b1, 10'd3, 10'd0, 1'b1, 1'b0);
		queue_glyph(1'b1, 10'd0, 10'd1000, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'd1000, 10'd20, 1'b0, 1'b0);
		queue_glyph(1'b0, 10'd0, 10'd0, 1'b1, 1'b1);
		queue_glyph(1'b1, 10'd0, 10'd0, 1'b0, 1'b0);
		queue_glyph(1'b1, 10'd1023, 10'd1021, 1'b1, 1'b0);
		queue_glyph(1'b1, 10'd4, 10'd4, 1'b1, 1'b0);
		queue_glyph(1'b1, 10'd4, 10'd4, 1'b1, 1'b1);

		foreach (phase_caps[i]) begin
			set_page_limit(LIMIT_W'(phase_caps[i]));
			queue_random_glyphs(phase_sizes[i]);
		end

		await_drain();
		repeat (10) @(negedge clk);
		fail_count += placements_due.size();

		$display("checked %0d results over %0d page-limit settings, %0d pages opened",
			results_seen, limit_writes, pages_opened);
		$display("placed %0d, missing %0d, too tall %0d, out of pages %0d; two long output hold-offs",
			status_tally[ST_PLACED], status_tally[ST_MISSING], status_tally[ST_TOO_TALL],
			status_tally[ST_NO_PAGE]);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

### sim.f
rtl/core/gasp_pkg.sv
rtl/core/glyph_atlas_shelf_packer.sv
rtl/core/gasp_checker.sv
sim/glyph_atlas_shelf_packer_tb.sv
